// File: rtl/core/airspeed_needle_dynamics_assert.svh
// Assertion macros for the airspeed needle block.
// Expects signals clk and rst_n in the scope that uses them.
`ifndef AIRSPEED_NEEDLE_DYNAMICS_ASSERT_SVH
`define AIRSPEED_NEEDLE_DYNAMICS_ASSERT_SVH

// same-cycle implication
`define ANU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anu: assertion failed");

// next-cycle implication
`define ANU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anu: assertion failed");

`endif

// File: rtl/core/anu_pkg.sv
// Shared types and constants for the airspeed needle block.
// No dependencies.
package anu_pkg;

    localparam int NUM_CFG = 6;

    localparam logic [2:0] CFG_SCALE_MIN   = 3'd0;
    localparam logic [2:0] CFG_SCALE_MAX   = 3'd1;
    localparam logic [2:0] CFG_FLAPS_STALL = 3'd2;
    localparam logic [2:0] CFG_CLEAN_STALL = 3'd3;
    localparam logic [2:0] CFG_MAX_CRUISE  = 3'd4;
    localparam logic [2:0] CFG_NEVER_EXC   = 3'd5;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_INIT   = 1'b1;

    localparam logic [2:0] ZONE_LOW_RED  = 3'd0;
    localparam logic [2:0] ZONE_WHITE    = 3'd1;
    localparam logic [2:0] ZONE_GREEN    = 3'd2;
    localparam logic [2:0] ZONE_YELLOW   = 3'd3;
    localparam logic [2:0] ZONE_HIGH_RED = 3'd4;

    typedef struct packed {
        logic start;
        logic is_div;
    } mdu_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WAIT,
        S_FDIV,
        S_FT,
        S_TGT,
        S_WDIV,
        S_WADD,
        S_WN,
        S_DN,
        S_DNW,
        S_CMUL,
        S_CDIV,
        S_CSET,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_RDIV,
        S_RATE,
        S_PM,
        S_PDIV,
        S_POS,
        S_CROSS,
        S_XDIV,
        S_XSET,
        S_OUT
    } state_t;

endpackage

// File: rtl/core/airspeed_needle_dynamics.sv
// Airspeed needle dynamics: EMA prefilter plus second-order needle model.
// Depends on anu_pkg, anu_mdu and airspeed_needle_dynamics_assert.svh.
//
// One sample is taken at a time, and the block is not ready while it works.
// An initialize item goes straight to the output register. An update item
// runs its multiplies and divides one after another on one shared bit-serial
// multiply/divide unit of width W = 2*FRAC_BITS+36 (68 at the default). A
// stiction snap stops after 2 operations; a full update runs 11 to 17
// operations. A previous result still waiting in the output register holds
// the finished item until that register is free.
// Divides by constants are reciprocal multiplies; only the filter divide and
// the scale-span divide use the serial divider. The result sits in an output
// register, so the next sample is taken while the previous result waits for
// transfer. Configuration must be written through wr_en/wr_index/wr_data
// only while idle; the block itself does not enforce it.
`include "airspeed_needle_dynamics_assert.svh"

module airspeed_needle_dynamics #(
    parameter int FRAC_BITS  = 16,
    parameter int TICK_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [2:0]            wr_index,
    input  logic [8:0]            wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic signed [18:0]    raw_speed,
    input  logic                  sample_invalid,
    input  logic [31:0]           now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FRAC_BITS+8:0]  shown_speed,
    output logic [8:0]            shown_speed_rounded,
    output logic [2:0]            colour_zone
);
    import anu_pkg::*;

    localparam int PW  = 9 + FRAC_BITS;
    localparam int RW  = FRAC_BITS + 11;
    localparam int SW  = FRAC_BITS + 19;
    localparam int W   = 2 * FRAC_BITS + 36;
    localparam int WNW = FRAC_BITS + 4;
    localparam int TW  = TICK_WIDTH;

    localparam int SNAP_INT = (35 * (1 << FRAC_BITS) + 50) / 100;
    localparam int HALF_INT = 9 * (1 << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SNAP_ERR  = SW'(SNAP_INT);
    localparam logic signed [SW-1:0] HALF_WN   = SW'(HALF_INT);
    localparam logic signed [SW-1:0] SNAP_RATE = SW'(2) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] A_MAX     = SW'(2200) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] R_MAX     = SW'(420) <<< FRAC_BITS;
    localparam logic [W-1:0] RND_HALF = W'(1) << (FRAC_BITS - 1);

    // reciprocals for the constant divisors: (y * M) >> SH is exact over
    // the operand range of each use
    localparam int SH_11 = FRAC_BITS + 11;
    localparam int SH_C  = FRAC_BITS + 14;
    localparam int SH_K  = FRAC_BITS + 27;
    localparam int SH_X  = FRAC_BITS + 18;
    localparam logic [W-1:0] M_11   = W'(((64'd1 << SH_11) + 64'd10) / 64'd11);
    localparam logic [W-1:0] M_5    = W'(((64'd1 << SH_C) + 64'd4) / 64'd5);
    localparam logic [W-1:0] M_25   = W'(((64'd1 << SH_C) + 64'd24) / 64'd25);
    localparam logic [W-1:0] M_1000 = W'(((64'd1 << SH_K) + 64'd999) / 64'd1000);
    localparam logic [W-1:0] M_20   = W'(((64'd1 << SH_X) + 64'd19) / 64'd20);

    function automatic logic signed [SW-1:0] clampv(
        input logic signed [SW-1:0] x,
        input logic signed [SW-1:0] lo,
        input logic signed [SW-1:0] hi
    );
        logic signed [SW-1:0] r;
        r = x;
        if (x < lo)
            r = lo;
        else if (x > hi)
            r = hi;
        return r;
    endfunction

    function automatic logic [W-1:0] absw(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] m;
        m = (x < 0) ? -x : x;
        return W'(m);
    endfunction

    function automatic logic signed [SW-1:0] signed_q(
        input logic         neg,
        input logic [W-1:0] m
    );
        logic signed [SW-1:0] v;
        v = $signed(SW'(m));
        return neg ? -v : v;
    endfunction

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [8:0]             cfg_reg [NUM_CFG];
    logic [PW-1:0]          ft_reg, ft_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic signed [RW-1:0]   rate_reg, rate_next;
    logic [TW-1:0]          last_reg, last_next;
    logic                   fseen_reg, fseen_next;
    logic                   mseen_reg, mseen_next;

    logic [6:0]             fdt_reg, fdt_next;
    logic [5:0]             mdt_reg, mdt_next;
    logic signed [SW-1:0]   tgt_reg, tgt_next;
    logic signed [SW-1:0]   err_reg, err_next;
    logic                   up_reg, up_next;
    logic [WNW-1:0]         wn_reg, wn_next;
    logic [WNW-1:0]         c_reg, c_next;
    logic signed [SW-1:0]   acc_reg, acc_next;
    logic                   neg_reg, neg_next;

    logic                   oval_reg, oval_next;
    logic [PW-1:0]          spd_reg;
    logic [8:0]             rnd_reg;
    logic [2:0]             zone_reg;
    logic                   load_out;

    mdu_ctl_t               mdu_ctl;
    logic [W-1:0]           mdu_a, mdu_b, mdu_res;
    logic                   mdu_done;

    logic signed [SW-1:0]   lo_s, hi_s, raw_s, raw_c, ft_s, pos_s, rate_s;
    logic signed [SW-1:0]   res_s, q_s, rnd_s, qr_s, diff_s, num_s, e1_s, tgt_c, err_c;
    logic [W-1:0]           rnd_w;
    logic [TW-1:0]          el;
    logic [6:0]             fdt_c;
    logic [5:0]             mdt_c;
    logic [PW:0]            spd_sum;

    anu_mdu #(.W(W)) u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mdu_ctl),
        .a     (mdu_a),
        .b     (mdu_b),
        .done  (mdu_done),
        .res   (mdu_res)
    );

    assign lo_s   = $signed(SW'(cfg_reg[CFG_SCALE_MIN])) <<< FRAC_BITS;
    assign hi_s   = $signed(SW'(cfg_reg[CFG_SCALE_MAX])) <<< FRAC_BITS;
    assign raw_s  = sample_invalid ? lo_s : (SW'(raw_speed) <<< (FRAC_BITS - 8));
    assign raw_c  = clampv(raw_s, lo_s, hi_s);
    assign ft_s   = $signed(SW'(ft_reg));
    assign pos_s  = $signed(SW'(pos_reg));
    assign rate_s = SW'(rate_reg);
    assign diff_s = raw_c - ft_s;
    assign tgt_c  = clampv(ft_s, lo_s, hi_s);
    assign err_c  = tgt_c - pos_s;
    assign num_s  = clampv(pos_s - lo_s, '0, hi_s - lo_s);
    assign e1_s   = tgt_reg - pos_s;

    assign res_s  = $signed(SW'(mdu_res));
    assign q_s    = neg_reg ? -res_s : res_s;
    assign rnd_w  = (mdu_res + RND_HALF) >> FRAC_BITS;
    assign rnd_s  = $signed(SW'(rnd_w));
    assign qr_s   = neg_reg ? -rnd_s : rnd_s;

    assign el    = now_ms[TW-1:0] - last_reg;
    assign fdt_c = !fseen_reg ? 7'd20 :
                   (el == '0) ? 7'd1 : (el > TW'(100)) ? 7'd100 : el[6:0];
    assign mdt_c = !mseen_reg ? 6'd20 :
                   (el == '0) ? 6'd1 : (el > TW'(50)) ? 6'd50 : el[5:0];

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ft_next    = ft_reg;
        pos_next   = pos_reg;
        rate_next  = rate_reg;
        last_next  = last_reg;
        fseen_next = fseen_reg;
        mseen_next = mseen_reg;
        fdt_next   = fdt_reg;
        mdt_next   = mdt_reg;
        tgt_next   = tgt_reg;
        err_next   = err_reg;
        up_next    = up_reg;
        wn_next    = wn_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        mdu_ctl    = '0;
        mdu_a      = '0;
        mdu_b      = '0;
        load_out   = 1'b0;
        oval_next  = oval_reg && !out_ready;
        in_ready   = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_INIT)
                    begin
                        ft_next    = PW'(raw_c);
                        pos_next   = PW'(raw_c);
                        rate_next  = '0;
                        mseen_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        fdt_next   = fdt_c;
                        mdt_next   = mdt_c;
                        last_next  = now_ms[TW-1:0];
                        fseen_next = 1'b1;
                        mseen_next = 1'b1;
                        neg_next   = diff_s < 0;
                        mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                        mdu_a      = absw(diff_s);
                        mdu_b      = W'(fdt_c);
                        ret_next   = S_FDIV;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (mdu_done)
                    state_next = ret_reg;
            end
            S_FDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b1};
                mdu_a      = mdu_res;
                mdu_b      = W'(fdt_reg) + W'(180);
                ret_next   = S_FT;
                state_next = S_WAIT;
            end
            S_FT:
            begin
                ft_next    = PW'(ft_s + q_s);
                state_next = S_TGT;
            end
            S_TGT:
            begin
                tgt_next = tgt_c;
                err_next = err_c;
                up_next  = tgt_c > pos_s;
                if (absw(err_c) < W'(SNAP_ERR) && absw(rate_s) < W'(SNAP_RATE))
                begin
                    // stiction: snap to target and stop
                    pos_next   = PW'(tgt_c);
                    rate_next  = '0;
                    state_next = S_OUT;
                end
                else if (hi_s > lo_s)
                begin
                    mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                    mdu_a      = W'(HALF_WN);
                    mdu_b      = absw(num_s);
                    ret_next   = S_WDIV;
                    state_next = S_WAIT;
                end
                else
                begin
                    wn_next    = WNW'(HALF_WN);
                    state_next = S_WN;
                end
            end
            S_WDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b1};
                mdu_a      = mdu_res;
                mdu_b      = absw(hi_s - lo_s);
                ret_next   = S_WADD;
                state_next = S_WAIT;
            end
            S_WADD:
            begin
                wn_next    = WNW'(W'(HALF_WN) + mdu_res);
                state_next = S_WN;
            end
            S_WN:
            begin
                if (up_reg)
                    state_next = S_CMUL;
                else
                begin
                    mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                    mdu_a      = W'(wn_reg);
                    mdu_b      = W'(10);
                    ret_next   = S_DN;
                    state_next = S_WAIT;
                end
            end
            S_DN:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = mdu_res + W'(5);
                mdu_b      = M_11;
                ret_next   = S_DNW;
                state_next = S_WAIT;
            end
            S_DNW:
            begin
                wn_next    = WNW'(mdu_res >> SH_11);
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = W'(wn_reg);
                mdu_b      = up_reg ? W'(7) : W'(41);
                ret_next   = S_CDIV;
                state_next = S_WAIT;
            end
            S_CDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = mdu_res + (up_reg ? W'(2) : W'(12));
                mdu_b      = up_reg ? M_5 : M_25;
                ret_next   = S_CSET;
                state_next = S_WAIT;
            end
            S_CSET:
            begin
                c_next     = WNW'(mdu_res >> SH_C);
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = W'(wn_reg);
                mdu_b      = W'(wn_reg);
                ret_next   = S_A1;
                state_next = S_WAIT;
            end
            S_A1:
            begin
                neg_next   = err_reg < 0;
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = rnd_w;
                mdu_b      = absw(err_reg);
                ret_next   = S_A2;
                state_next = S_WAIT;
            end
            S_A2:
            begin
                acc_next   = qr_s;
                neg_next   = rate_s < 0;
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = W'(c_reg);
                mdu_b      = absw(rate_s);
                ret_next   = S_A3;
                state_next = S_WAIT;
            end
            S_A3:
            begin
                acc_next   = clampv(acc_reg - qr_s, -A_MAX, A_MAX);
                state_next = S_A4;
            end
            S_A4:
            begin
                neg_next   = acc_reg < 0;
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = absw(acc_reg);
                mdu_b      = W'(mdt_reg);
                ret_next   = S_RDIV;
                state_next = S_WAIT;
            end
            S_RDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = mdu_res + W'(500);
                mdu_b      = M_1000;
                ret_next   = S_RATE;
                state_next = S_WAIT;
            end
            S_RATE:
            begin
                rate_next  = RW'(clampv(rate_s + signed_q(neg_reg, mdu_res >> SH_K),
                                        -R_MAX, R_MAX));
                state_next = S_PM;
            end
            S_PM:
            begin
                neg_next   = rate_s < 0;
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = absw(rate_s);
                mdu_b      = W'(mdt_reg);
                ret_next   = S_PDIV;
                state_next = S_WAIT;
            end
            S_PDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = mdu_res + W'(500);
                mdu_b      = M_1000;
                ret_next   = S_POS;
                state_next = S_WAIT;
            end
            S_POS:
            begin
                pos_next   = PW'(clampv(pos_s + signed_q(neg_reg, mdu_res >> SH_K),
                                        lo_s, hi_s));
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                // overshoot past the target: damp the rate
                if ((err_reg > 0 && e1_s < 0) || (err_reg < 0 && e1_s > 0))
                begin
                    neg_next   = rate_s < 0;
                    mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                    mdu_a      = absw(rate_s);
                    mdu_b      = W'(11);
                    ret_next   = S_XDIV;
                    state_next = S_WAIT;
                end
                else
                    state_next = S_OUT;
            end
            S_XDIV:
            begin
                mdu_ctl    = '{start: 1'b1, is_div: 1'b0};
                mdu_a      = mdu_res + W'(10);
                mdu_b      = M_20;
                ret_next   = S_XSET;
                state_next = S_WAIT;
            end
            S_XSET:
            begin
                rate_next  = RW'(signed_q(neg_reg, mdu_res >> SH_X));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!oval_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign spd_sum = {1'b0, pos_reg} + (PW+1)'(RND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cfg_reg[CFG_SCALE_MIN]   <= 9'd40;
            cfg_reg[CFG_SCALE_MAX]   <= 9'd280;
            cfg_reg[CFG_FLAPS_STALL] <= 9'd65;
            cfg_reg[CFG_CLEAN_STALL] <= 9'd75;
            cfg_reg[CFG_MAX_CRUISE]  <= 9'd180;
            cfg_reg[CFG_NEVER_EXC]   <= 9'd250;
            ft_reg    <= PW'(40) << FRAC_BITS;
            pos_reg   <= PW'(40) << FRAC_BITS;
            rate_reg  <= '0;
            last_reg  <= '0;
            fseen_reg <= 1'b0;
            mseen_reg <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (wr_en && wr_index < 3'(NUM_CFG))
                cfg_reg[wr_index] <= wr_data;
            ft_reg    <= ft_next;
            pos_reg   <= pos_next;
            rate_reg  <= rate_next;
            last_reg  <= last_next;
            fseen_reg <= fseen_next;
            mseen_reg <= mseen_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fdt_reg <= fdt_next;
        mdt_reg <= mdt_next;
        tgt_reg <= tgt_next;
        err_reg <= err_next;
        up_reg  <= up_next;
        wn_reg  <= wn_next;
        c_reg   <= c_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        if (load_out)
        begin
            spd_reg <= pos_reg;
            rnd_reg <= spd_sum[PW-1:FRAC_BITS];
            priority if (pos_reg[PW-1:FRAC_BITS] >= cfg_reg[CFG_NEVER_EXC])
                zone_reg <= ZONE_HIGH_RED;
            else if (pos_reg[PW-1:FRAC_BITS] >= cfg_reg[CFG_MAX_CRUISE])
                zone_reg <= ZONE_YELLOW;
            else if (pos_reg[PW-1:FRAC_BITS] >= cfg_reg[CFG_CLEAN_STALL])
                zone_reg <= ZONE_GREEN;
            else if (pos_reg[PW-1:FRAC_BITS] >= cfg_reg[CFG_FLAPS_STALL])
                zone_reg <= ZONE_WHITE;
            else
                zone_reg <= ZONE_LOW_RED;
        end
    end

    assign out_valid           = oval_reg;
    assign shown_speed         = spd_reg;
    assign shown_speed_rounded = rnd_reg;
    assign colour_zone         = zone_reg;

    `ANU_ASSERT_SAME(a_done_in_wait, mdu_done, state_reg == S_WAIT)
    `ANU_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
    `ANU_ASSERT_SAME(a_result_from_out, $rose(oval_reg), $past(state_reg) == S_OUT)

endmodule

// File: rtl/core/anu_mdu.sv
// Bit-serial unsigned multiply and rounded divide unit.
// Depends on anu_pkg for the control struct.
module anu_mdu #(
    parameter int W = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  anu_pkg::mdu_ctl_t ctl,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic              done,
    output logic [W-1:0]      res
);
    import anu_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic          div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W:0]    trial;
    logic          ge;

    assign trial = {rem_reg[W-1:0], x_reg[W-1]};
    assign ge    = trial >= {1'b0, y_reg};

    always_comb
    begin
        run_next  = run_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            run_next = 1'b1;
            div_next = ctl.is_div;
            cnt_next = '0;
            acc_next = '0;
            rem_next = '0;
            y_next   = b;
            // bias the dividend by half the divisor for round to nearest
            x_next   = ctl.is_div ? a + (b >> 1) : a;
        end
        else if (run_reg)
        begin
            if (div_reg)
            begin
                rem_next = ge ? trial - {1'b0, y_reg} : trial;
                x_next   = {x_reg[W-2:0], ge};
            end
            else
            begin
                acc_next = y_reg[0] ? acc_reg + x_reg : acc_reg;
                x_next   = x_reg << 1;
                y_next   = y_reg >> 1;
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign res  = div_reg ? x_reg : acc_reg;

endmodule
